// File: rtl/core/bce_pkg.sv
package bce_pkg;

  localparam int NUM_BALLS = 32;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = $clog2(NUM_BALLS);
  localparam int CNT_W     = $clog2(NUM_BALLS + 1);
  localparam int LIM_W     = 31 + FRAC_BITS;
  // dividend width of the exchange divide: |dot| (59 bits) times |d| (24 bits)
  localparam int NUM_W     = 83;
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [2:0] REG_BALL_COUNT   = 3'd0;
  localparam logic [2:0] REG_TIME_STEP    = 3'd1;
  localparam logic [2:0] REG_GRAVITY_Y    = 3'd2;
  localparam logic [2:0] REG_RESTITUTION  = 3'd3;
  localparam logic [2:0] REG_FLOOR_HEIGHT = 3'd4;
  localparam logic [2:0] REG_CONTACT_DIST = 3'd5;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } ball_t;

  typedef struct packed {
    logic [6:0]         ball_count;
    logic [16:0]        time_step;
    logic signed [31:0] gravity_y;
    logic [16:0]        restitution;
    logic signed [31:0] floor_height;
    logic [30:0]        contact_dist_sq;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_RD, OP_CAP_A, OP_FLR_MUL, OP_FLR_SAT, OP_CAP_B, OP_SQ,
    OP_DOT, OP_PROD_LO, OP_PROD_HI, OP_DIV_STEP, OP_UPD, OP_WR_B, OP_GRAV_MUL,
    OP_GRAV_ADD, OP_POS_MUL, OP_POS_ADD, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        k;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic contact;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_I, S_CAP_A, S_FLR_MUL, S_FLR_SAT, S_J_CHK, S_CAP_B, S_SQ,
    S_TEST, S_DOT, S_PROD_LO, S_PROD_HI, S_DIV, S_UPD, S_WR_B, S_GRAV_MUL,
    S_GRAV_ADD, S_POS_MUL, S_POS_ADD, S_EMIT
  } ctl_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

// File: rtl/core/bce_req_if.sv
interface bce_req_if;
  import bce_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [5:0]         ball_index;
  logic signed [31:0] pos_x_in;
  logic signed [31:0] pos_y_in;
  logic signed [31:0] pos_z_in;
  logic signed [31:0] vel_x_in;
  logic signed [31:0] vel_y_in;
  logic signed [31:0] vel_z_in;

  modport source(output valid, command, ball_index, pos_x_in, pos_y_in, pos_z_in,
                 vel_x_in, vel_y_in, vel_z_in, input ready);
  modport sink(input valid, command, ball_index, pos_x_in, pos_y_in, pos_z_in,
               vel_x_in, vel_y_in, vel_z_in, output ready);
endinterface

// File: rtl/core/bce_rsp_if.sv
interface bce_rsp_if;
  import bce_pkg::*;
  logic               valid;
  logic               ready;
  logic [5:0]         out_index;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] pos_z_out;
  logic signed [31:0] vel_x_out;
  logic signed [31:0] vel_y_out;
  logic signed [31:0] vel_z_out;
  logic               last_ball;

  modport source(output valid, out_index, pos_x_out, pos_y_out, pos_z_out,
                 vel_x_out, vel_y_out, vel_z_out, last_ball, input ready);
  modport sink(input valid, out_index, pos_x_out, pos_y_out, pos_z_out,
               vel_x_out, vel_y_out, vel_z_out, last_ball, output ready);
endinterface

// File: rtl/core/bce_cfg_if.sv
interface bce_cfg_if;
  import bce_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/bce_datapath.sv
module bce_datapath (
  input  logic                       clk,
  input  bce_pkg::dp_cmd_t           cmd,
  input  bce_pkg::cfg_t              cfg,
  input  logic [5:0]                 load_index,
  input  bce_pkg::ball_t             load_ball,
  output bce_pkg::dp_status_t        status,
  output bce_pkg::ball_t             out_ball,
  output logic [5:0]                 out_index,
  output logic                       out_last
);
  import bce_pkg::*;

  ball_t mem [NUM_BALLS];
  ball_t rdata;

  logic signed [31:0] pa [3];
  logic signed [31:0] va [3];
  logic signed [31:0] pb [3];
  logic signed [31:0] vb [3];
  logic signed [32:0] d [3];
  logic               far;
  logic [49:0]        s;
  logic signed [59:0] dot;
  logic [52:0]        plo;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   q;
  logic [49:0]        rem;
  logic signed [49:0] mprod;

  logic signed [31:0] rpos [3];
  logic signed [31:0] rvel [3];
  logic signed [32:0] dn [3];
  logic [2:0]         dn_far;
  logic [32:0]        dk_mag;
  logic [23:0]        ad_k;
  logic [59:0]        dot_mag;
  logic [58:0]        adot;
  logic signed [32:0] vdiff;
  logic signed [24:0] dk25;
  logic signed [57:0] dprod;
  logic [53:0]        hi_prod;
  logic [52:0]        lo_prod;
  logic [50:0]        r2;
  logic               neg;
  logic signed [63:0] delta;
  logic signed [17:0] ts_s;
  logic signed [63:0] neg_p;
  logic [LIM_W-1:0]   limit;

  always_comb begin
    rpos[0] = rdata.pos_x;
    rpos[1] = rdata.pos_y;
    rpos[2] = rdata.pos_z;
    rvel[0] = rdata.vel_x;
    rvel[1] = rdata.vel_y;
    rvel[2] = rdata.vel_z;
    for (int c = 0; c < 3; c++) begin
      dn[c] = 33'(rpos[c]) - 33'(pa[c]);
      // near only inside the open range of +-2^24
      dn_far[c] = !((dn[c][32:24] == 9'h000) ||
                    ((dn[c][32:24] == 9'h1ff) && (dn[c][23:0] != 24'h0)));
    end
  end

  assign dk_mag  = d[cmd.k][32] ? 33'(-d[cmd.k]) : 33'(d[cmd.k]);
  assign ad_k    = dk_mag[23:0];
  assign dot_mag = dot[59] ? 60'(-dot) : 60'(dot);
  assign adot    = dot_mag[58:0];
  assign vdiff   = 33'(vb[cmd.k]) - 33'(va[cmd.k]);
  assign dk25    = d[cmd.k][24:0];
  assign dprod   = vdiff * dk25;
  assign hi_prod = adot[58:29] * ad_k;
  assign lo_prod = adot[28:0] * ad_k;
  assign r2      = {rem, num[NUM_W-1]};
  assign neg     = dot[59] ^ d[cmd.k][32];
  assign delta   = neg ? -$signed({5'b0, q[58:0]}) : $signed({5'b0, q[58:0]});
  assign ts_s    = $signed({1'b0, cfg.time_step});
  assign neg_p   = -64'(mprod);
  assign limit   = LIM_W'(cfg.contact_dist_sq) << FRAC_BITS;

  assign status.contact = !far && (s != '0) && (s < 50'(limit));

  // ball store, one row per ball
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        if (7'(load_index) < 7'(NUM_BALLS)) mem[load_index[ADDR_W-1:0]] <= load_ball;
      end
      OP_WR_B: mem[cmd.addr] <= '{pb[0], pb[1], pb[2], vb[0], vb[1], vb[2]};
      OP_EMIT: mem[cmd.addr] <= '{pa[0], pa[1], pa[2], va[0], va[1], va[2]};
      default: ;
    endcase
    if (cmd.op == OP_RD) rdata <= mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAP_A: begin
        for (int c = 0; c < 3; c++) begin
          pa[c] <= rpos[c];
          va[c] <= rvel[c];
        end
      end
      OP_FLR_MUL: mprod <= $signed({1'b0, cfg.restitution}) * va[1];
      OP_FLR_SAT: begin
        if (pa[1] < cfg.floor_height) va[1] <= sat32(neg_p >>> FRAC_BITS);
      end
      OP_CAP_B: begin
        for (int c = 0; c < 3; c++) begin
          pb[c] <= rpos[c];
          vb[c] <= rvel[c];
          d[c]  <= dn[c];
        end
        far <= |dn_far;
        s   <= '0;
        dot <= '0;
      end
      OP_SQ:      s   <= s + 50'(ad_k * ad_k);
      OP_DOT:     dot <= dot + 60'(dprod);
      OP_PROD_LO: plo <= lo_prod;
      OP_PROD_HI: begin
        num <= {hi_prod, 29'b0} + NUM_W'(plo);
        rem <= '0;
        q   <= '0;
      end
      OP_DIV_STEP: begin
        // restoring divide, one quotient bit a cycle
        if (r2 >= {1'b0, s}) begin
          rem <= 50'(r2 - {1'b0, s});
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= r2[49:0];
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        num <= {num[NUM_W-2:0], 1'b0};
      end
      OP_UPD: begin
        va[cmd.k] <= sat32(64'(va[cmd.k]) + delta);
        vb[cmd.k] <= sat32(64'(vb[cmd.k]) - delta);
      end
      OP_GRAV_MUL: mprod <= cfg.gravity_y * ts_s;
      OP_GRAV_ADD: va[1] <= sat32(64'(va[1]) + (64'(mprod) >>> FRAC_BITS));
      OP_POS_MUL:  mprod <= va[cmd.k] * ts_s;
      OP_POS_ADD:  pa[cmd.k] <= sat32(64'(pa[cmd.k]) + (64'(mprod) >>> FRAC_BITS));
      OP_EMIT: begin
        out_ball  <= '{pa[0], pa[1], pa[2], va[0], va[1], va[2]};
        out_index <= 6'(cmd.addr);
        out_last  <= cmd.last;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/bce_ctrl.sv
module bce_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic                     req_command,
  output logic                     req_ready,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  input  logic [bce_pkg::CNT_W-1:0] n,
  input  bce_pkg::dp_status_t      status,
  output bce_pkg::dp_cmd_t         cmd
);
  import bce_pkg::*;

  ctl_state_t        state, state_next;
  logic [CNT_W-1:0]  i, j;
  logic [1:0]        k;
  logic [DCNT_W-1:0] dcnt;
  logic              slot_free;
  logic              emit;

  assign slot_free = !rsp_valid || rsp_ready;
  assign emit      = (state == S_EMIT) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && (req_command == CMD_STEP) && (n != '0)) state_next = S_RD_I;
      end
      S_RD_I:    state_next = S_CAP_A;
      S_CAP_A:   state_next = S_FLR_MUL;
      S_FLR_MUL: state_next = S_FLR_SAT;
      S_FLR_SAT: state_next = S_J_CHK;
      S_J_CHK:   state_next = (j < n) ? S_CAP_B : S_GRAV_MUL;
      S_CAP_B:   state_next = S_SQ;
      S_SQ:      if (k == 2'd2) state_next = S_TEST;
      S_TEST:    state_next = status.contact ? S_DOT : S_J_CHK;
      S_DOT:     if (k == 2'd2) state_next = S_PROD_LO;
      S_PROD_LO: state_next = S_PROD_HI;
      S_PROD_HI: state_next = S_DIV;
      S_DIV:     if (dcnt == DCNT_W'(DIV_STEPS - 1)) state_next = S_UPD;
      S_UPD:     state_next = (k == 2'd2) ? S_WR_B : S_PROD_LO;
      S_WR_B:    state_next = S_J_CHK;
      S_GRAV_MUL: state_next = S_GRAV_ADD;
      S_GRAV_ADD: state_next = S_POS_MUL;
      S_POS_MUL:  state_next = S_POS_ADD;
      S_POS_ADD:  state_next = (k == 2'd2) ? S_EMIT : S_POS_MUL;
      S_EMIT: begin
        if (slot_free) state_next = (i + 1'b1 < n) ? S_RD_I : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd.op    = OP_NOP;
    cmd.addr  = i[ADDR_W-1:0];
    cmd.k     = k;
    cmd.last  = (i + 1'b1 == n);
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && (req_command == CMD_LOAD)) cmd.op = OP_LOAD;
      end
      S_RD_I:    cmd.op = OP_RD;
      S_CAP_A:   cmd.op = OP_CAP_A;
      S_FLR_MUL: cmd.op = OP_FLR_MUL;
      S_FLR_SAT: cmd.op = OP_FLR_SAT;
      S_J_CHK: begin
        cmd.addr = j[ADDR_W-1:0];
        if (j < n) cmd.op = OP_RD;
      end
      S_CAP_B:   cmd.op = OP_CAP_B;
      S_SQ:      cmd.op = OP_SQ;
      S_DOT:     cmd.op = OP_DOT;
      S_PROD_LO: cmd.op = OP_PROD_LO;
      S_PROD_HI: cmd.op = OP_PROD_HI;
      S_DIV:     cmd.op = OP_DIV_STEP;
      S_UPD:     cmd.op = OP_UPD;
      S_WR_B: begin
        cmd.op   = OP_WR_B;
        cmd.addr = j[ADDR_W-1:0];
      end
      S_GRAV_MUL: cmd.op = OP_GRAV_MUL;
      S_GRAV_ADD: cmd.op = OP_GRAV_ADD;
      S_POS_MUL:  cmd.op = OP_POS_MUL;
      S_POS_ADD:  cmd.op = OP_POS_ADD;
      S_EMIT:     if (slot_free) cmd.op = OP_EMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      dcnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE:  i <= '0;
        S_CAP_A: j <= i + 1'b1;
        S_TEST:  if (!status.contact) j <= j + 1'b1;
        S_WR_B:  j <= j + 1'b1;
        S_SQ, S_DOT, S_UPD, S_POS_ADD: k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        S_PROD_HI: dcnt <= '0;
        S_DIV:     dcnt <= dcnt + 1'b1;
        S_EMIT:    if (slot_free) i <= i + 1'b1;
        default: ;
      endcase
    end
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> (!rsp_valid || rsp_ready))
    else $error("result emitted over a waiting one");
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_I) |-> (i < n))
    else $error("ball read beyond count");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CAP_B) |-> (j > i))
    else $error("pair partner not above current ball");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dcnt < DCNT_W'(DIV_STEPS)))
    else $error("divide ran too long");

endmodule

// File: rtl/core/ball_collision_euler_step.sv
// Ball collision and Euler step engine. Load items (command 0) write one ball
// row each; rows at or above the store depth are dropped. A step item
// (command 1) runs one frame over the first min(ball_count, 32) balls and
// yields one result per ball in index order, the last flagged. The block takes
// no item while a frame runs. Per ball the sequencer reads the ball, applies the
// floor bounce, tests each higher-indexed ball for contact and, for each touching
// pair, runs three restoring divides by the squared distance, one quotient bit
// a cycle; then it adds gravity, moves the ball and emits it. All ball state
// sits in one single-port store read one row a cycle. A result waits in an
// output register and the next ball's work goes on behind it; a ball ready to
// emit holds while the previous result still waits.
module ball_collision_euler_step (
  input logic       clk,
  input logic       rst,
  bce_req_if.sink   req,
  bce_rsp_if.source rsp,
  bce_cfg_if.sink   cfg
);
  import bce_pkg::*;

  cfg_t             regs;
  logic [CNT_W-1:0] n;
  dp_cmd_t          cmd;
  dp_status_t       status;
  ball_t            load_ball;
  ball_t            out_ball;
  logic [5:0]       out_index;
  logic             out_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ball_count      <= 7'd20;
      regs.time_step       <= 17'd1966;
      regs.gravity_y       <= -32'sd131072;
      regs.restitution     <= 17'd52429;
      regs.floor_height    <= 32'sd32768;
      regs.contact_dist_sq <= 31'd65536;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BALL_COUNT:   regs.ball_count      <= cfg.data[6:0];
        REG_TIME_STEP:    regs.time_step       <= cfg.data[16:0];
        REG_GRAVITY_Y:    regs.gravity_y       <= cfg.data;
        REG_RESTITUTION:  regs.restitution     <= cfg.data[16:0];
        REG_FLOOR_HEIGHT: regs.floor_height    <= cfg.data;
        REG_CONTACT_DIST: regs.contact_dist_sq <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // counts above the store depth are clamped
  assign n = (regs.ball_count > 7'(NUM_BALLS)) ? CNT_W'(NUM_BALLS)
                                              : CNT_W'(regs.ball_count);

  assign load_ball = '{req.pos_x_in, req.pos_y_in, req.pos_z_in,
                       req.vel_x_in, req.vel_y_in, req.vel_z_in};

  bce_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .n           (n),
    .status      (status),
    .cmd         (cmd)
  );

  bce_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .cfg        (regs),
    .load_index (req.ball_index),
    .load_ball  (load_ball),
    .status     (status),
    .out_ball   (out_ball),
    .out_index  (out_index),
    .out_last   (out_last)
  );

  assign rsp.out_index = out_index;
  assign rsp.pos_x_out = out_ball.pos_x;
  assign rsp.pos_y_out = out_ball.pos_y;
  assign rsp.pos_z_out = out_ball.pos_z;
  assign rsp.vel_x_out = out_ball.vel_x;
  assign rsp.vel_y_out = out_ball.vel_y;
  assign rsp.vel_z_out = out_ball.vel_z;
  assign rsp.last_ball = out_last;

endmodule
